// ----- rtl/tesp_pkg.sv -----
// ---------------------------------------------------------------------------
// tesp_pkg
// Types and constants shared by the tagged element stream parser modules.
// ---------------------------------------------------------------------------
package tesp_pkg;

  localparam int unsigned DIGIT_W = 4;

  localparam logic [31:0] MAX_LEN_RESET = 32'd104857600;

  // ascii codes used by the tag and number checks
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  localparam logic [DIGIT_W-1:0] TAG_PREFIX_LEN = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] HEX_DIGITS     = DIGIT_W'(8);

  typedef enum logic [4:0] {
    PH_TAG  = 5'b00001,
    PH_HEX  = 5'b00010,
    PH_NUM  = 5'b00100,
    PH_STR  = 5'b01000,
    PH_HALT = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_INS  = 3'd0,
    KIND_INT  = 3'd1,
    KIND_HDR  = 3'd2,
    KIND_BYTE = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_TAG   = 3'd0,
    ERR_BAD_HEX   = 3'd1,
    ERR_EMPTY_NUM = 3'd2,
    ERR_NO_GT     = 3'd3,
    ERR_BAD_DIGIT = 3'd4,
    ERR_TOO_LONG  = 3'd5,
    ERR_OVERFLOW  = 3'd6
  } err_t;

  typedef struct packed {
    phase_t             phase;
    logic [15:0]        tag_chars;
    logic [DIGIT_W-1:0] digit_count;
    logic [31:0]        acc;
    logic               num_is_len;
    logic [31:0]        bytes_rem;
  } parse_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    err_t        error_code;
    logic        last;
  } result_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:       PH_TAG,
    tag_chars:   16'd0,
    digit_count: '0,
    acc:         32'd0,
    num_is_len:  1'b0,
    bytes_rem:   32'd0
  };

endpackage

// ----- rtl/tesp_step.sv -----
// ---------------------------------------------------------------------------
// tesp_step
// Next parser state and optional result for one byte of the element stream.
// ---------------------------------------------------------------------------
module tesp_step
  import tesp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         start_over,
  input  logic [31:0]  max_len,
  output parse_state_t st_nxt,
  output logic         res_valid,
  output result_t      res
);

  logic               hex_ok;
  logic [3:0]         hex_val;
  logic               is_digit;
  logic [3:0]         dec_val;
  logic [35:0]        dec_sum;
  logic [DIGIT_W-1:0] cnt_inc;
  logic [31:0]        rem_dec;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte >= CH_0 && data_byte <= CH_9) begin
      hex_val = 4'(data_byte - CH_0);
    end else if (data_byte >= CH_LA && data_byte <= CH_LF) begin
      hex_val = 4'(data_byte - CH_LA + 8'd10);
    end else if (data_byte >= CH_UA && data_byte <= CH_UF) begin
      hex_val = 4'(data_byte - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign dec_val  = 4'(data_byte - CH_0);
  // acc*10 + digit as acc*8 + acc*2 + digit, upper bits flag overflow
  assign dec_sum  = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {32'd0, dec_val};
  assign cnt_inc  = st.digit_count + DIGIT_W'(1);
  assign rem_dec  = (st.bytes_rem != 32'd0) ? st.bytes_rem - 32'd1 : st.bytes_rem;

  always_comb begin
    st_nxt         = st;
    res_valid      = 1'b0;
    res.kind       = KIND_ERR;
    res.value      = 32'd0;
    res.error_code = ERR_BAD_TAG;
    res.last       = 1'b0;

    if (start_over) begin
      st_nxt = PARSE_CLEAR;
    end else begin
      unique case (st.phase)
        PH_TAG: begin
          if (st.digit_count < TAG_PREFIX_LEN) begin
            st_nxt.tag_chars   = {st.tag_chars[7:0], data_byte};
            st_nxt.digit_count = cnt_inc;
          end else begin
            st_nxt.digit_count = '0;
            st_nxt.acc         = 32'd0;
            st_nxt.tag_chars   = 16'd0;
            if (st.tag_chars == {CH_I, CH_N} && data_byte == CH_S) begin
              st_nxt.phase = PH_HEX;
            end else if (st.tag_chars == {CH_I, CH_N} && data_byte == CH_T) begin
              st_nxt.phase      = PH_NUM;
              st_nxt.num_is_len = 1'b0;
            end else if (st.tag_chars == {CH_S, CH_T} && data_byte == CH_R) begin
              st_nxt.phase      = PH_NUM;
              st_nxt.num_is_len = 1'b1;
            end else begin
              st_nxt.phase   = PH_HALT;
              res_valid      = 1'b1;
              res.error_code = ERR_BAD_TAG;
            end
          end
        end
        PH_HEX: begin
          if (!hex_ok) begin
            st_nxt.phase   = PH_HALT;
            res_valid      = 1'b1;
            res.error_code = ERR_BAD_HEX;
          end else if (cnt_inc == HEX_DIGITS) begin
            st_nxt    = PARSE_CLEAR;
            res_valid = 1'b1;
            res.kind  = KIND_INS;
            res.value = {st.acc[27:0], hex_val};
          end else begin
            st_nxt.acc         = {st.acc[27:0], hex_val};
            st_nxt.digit_count = cnt_inc;
          end
        end
        PH_NUM: begin
          res_valid = 1'b1;
          if (data_byte == CH_GT) begin
            if (st.digit_count == '0) begin
              st_nxt.phase   = PH_HALT;
              res.error_code = ERR_EMPTY_NUM;
            end else if (!st.num_is_len) begin
              st_nxt    = PARSE_CLEAR;
              res.kind  = KIND_INT;
              res.value = st.acc;
            end else if (st.acc > max_len) begin
              st_nxt.phase   = PH_HALT;
              res.error_code = ERR_TOO_LONG;
            end else begin
              st_nxt    = PARSE_CLEAR;
              res.kind  = KIND_HDR;
              res.value = st.acc;
              if (st.acc != 32'd0) begin
                st_nxt.phase     = PH_STR;
                st_nxt.bytes_rem = st.acc;
              end else begin
                res.last = 1'b1;
              end
            end
          end else if (st.digit_count >= DIGIT_W'(MAX_DIGITS)) begin
            st_nxt.phase   = PH_HALT;
            res.error_code = ERR_NO_GT;
          end else if (!is_digit) begin
            st_nxt.phase   = PH_HALT;
            res.error_code = ERR_BAD_DIGIT;
          end else if (dec_sum[35:32] != 4'd0) begin
            st_nxt.phase   = PH_HALT;
            res.error_code = ERR_OVERFLOW;
          end else begin
            res_valid          = 1'b0;
            st_nxt.acc         = dec_sum[31:0];
            st_nxt.digit_count = cnt_inc;
          end
        end
        PH_STR: begin
          res_valid = 1'b1;
          res.kind  = KIND_BYTE;
          res.value = {24'd0, data_byte};
          if (rem_dec == 32'd0) begin
            st_nxt   = PARSE_CLEAR;
            res.last = 1'b1;
          end else begin
            st_nxt.bytes_rem = rem_dec;
          end
        end
        default: begin
          // halted: hold everything until start over
        end
      endcase
    end
  end

endmodule

// ----- rtl/tagged_element_stream_parser.sv -----
// ---------------------------------------------------------------------------
// tagged_element_stream_parser
// Byte-wide parser for INS / INT / STR tagged elements with error halt.
// ---------------------------------------------------------------------------
// usage
//   in_*  : one stream byte per item, with in_start_over to restart parsing
//   out_* : at most one result item per input item (value, string header,
//           string byte or error code), last_of_string marks string ends
//   cfg_* : write of the maximum string length, always ready, use while idle
// timing
//   an item is registered at acceptance and parsed from the input register
//   once the result register can take its result, which is then registered
//   there and shown on out_* until it is taken
//   one item per cycle is sustained while out_stall is low; the parse is a single
//   pass through the step logic between the input register and the result register
// stalls
//   out_stall holds a full result register; the input register then holds its
//   item and in_stall rises, so nothing is lost or repeated
// reset
//   synchronous active-low rst_n empties both registers, returns the parser
//   to the start of a tag and loads the default maximum string length
// ---------------------------------------------------------------------------
module tagged_element_stream_parser
  import tesp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_over,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_string,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_string_length
);

  // input register
  logic         in_valid_r;
  logic [7:0]   in_data_r;
  logic         in_start_r;

  // parser state and limit
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic [31:0]  max_len_r;

  // result register
  logic         out_valid_r;
  result_t      out_res_r;

  logic         step_res_valid;
  result_t      step_res;
  logic         advance;
  logic         process;

  // the result register can take a new result when empty or draining
  assign advance  = !out_valid_r || !out_stall;
  assign process  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  assign cfg_ready = 1'b1;

  tesp_step #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_step (
    .st         (state_r),
    .data_byte  (in_data_r),
    .start_over (in_start_r),
    .max_len    (max_len_r),
    .st_nxt     (state_nxt),
    .res_valid  (step_res_valid),
    .res        (step_res)
  );

  // input register: loads whenever it is not holding a stalled item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r  <= in_data_byte;
      in_start_r <= in_start_over;
    end
  end

  // parser state advances once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PARSE_CLEAR;
    end else if (process) begin
      state_r <= state_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_string_length;
    end
  end

  // result register: refilled or emptied whenever it may move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= process && step_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process && step_res_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_value          = out_res_r.value;
  assign out_error_code     = out_res_r.error_code;
  assign out_last_of_string = out_res_r.last;

endmodule
